>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
    else $error("check failed");
// Implication that is checked during reset too.
`define CHK_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) cond) else $error("check failed");
`endif

>>> rtl/npss_pkg.sv
// Package for the nearest path segment search block: widths, constants, types.
// No dependencies.
package npss_pkg;
  localparam int CoordW    = 24;
  localparam int LookW     = 23;
  localparam int CountW    = 5;
  localparam int SlotW     = 4;
  localparam int IdxW      = 4;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 23;
  localparam int DefMaxPoints = 16;
  localparam int DiffW     = 25;
  localparam int SqW       = 50;
  localparam int SumW      = 51;
  localparam int DistW     = 26;
  localparam int RatioW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_LOOKAHEAD = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_POINTS    = 1'd1;
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load_pts;   // read both points of current segment
    logic       dist_start; // start one distance computation
    logic [1:0] dist_sel;   // 0 di, 1 dj, 2 dij
    logic       div_start;
    logic       clear_best;
    logic       update;     // compare ratio and maybe keep it
  } npss_cmd_t;

  typedef struct packed {
    logic dist_done;
    logic div_done;
    logic dij_zero;
  } npss_stat_t;

  localparam logic [1:0] SEL_DI  = 2'd0;
  localparam logic [1:0] SEL_DJ  = 2'd1;
  localparam logic [1:0] SEL_DIJ = 2'd2;
endpackage

>>> rtl/npss_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type is a parameter.
interface npss_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/npss_ctrl.sv
// Controller for the segment search: sequences loads, distances, divides.
// Depends on npss_pkg.
module npss_ctrl #(
  parameter int MaxPoints = npss_pkg::DefMaxPoints,
  parameter int PtW = $clog2(MaxPoints)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [npss_pkg::CountW-1:0]   n_pts,
  input  npss_pkg::npss_stat_t          stat,
  output npss_pkg::npss_cmd_t           cmd,
  output logic [PtW-1:0]                seg_idx,
  output logic                          busy,
  output logic                          done
);
  import npss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIST = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_NEXT = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     sel_r, sel_nxt;
  logic [PtW-1:0] idx_r, idx_nxt;
  logic [CountW:0] n_eff;
  logic            last_seg;

  assign n_eff = ({1'b0, n_pts} > (CountW+1)'(MaxPoints)) ?
                 (CountW+1)'(MaxPoints) : {1'b0, n_pts};
  assign last_seg = ((CountW+1)'(idx_r) + (CountW+1)'(2)) >= n_eff;
  assign seg_idx = idx_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt = sel_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.dist_sel = sel_r;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.clear_best = 1'b1;
          idx_nxt = '0;
          if (n_eff < (CountW+1)'(2)) begin
            done = 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.load_pts = 1'b1;
        sel_nxt = SEL_DI;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.dist_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.dist_done) begin
          if (sel_r == SEL_DIJ) begin
            state_nxt = S_DIV;
          end else begin
            sel_nxt = sel_r + 2'd1;
            state_nxt = S_DIST;
          end
        end
      end
      S_DIV: begin
        if (stat.dij_zero) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.update = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_seg) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + PtW'(1);
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r <= SEL_DI;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r <= sel_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

>>> rtl/npss_dp.sv
// Datapath: waypoint memory, squared distance, serial square root and divider.
// Depends on npss_pkg.
module npss_dp #(
  parameter int MaxPoints = npss_pkg::DefMaxPoints,
  parameter int PtW = $clog2(MaxPoints)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [npss_pkg::SlotW-1:0]   wr_slot,
  input  logic [npss_pkg::CoordW-1:0]  wr_x,
  input  logic [npss_pkg::CoordW-1:0]  wr_y,
  input  logic                         q_start,
  input  logic [npss_pkg::CoordW-1:0]  q_x,
  input  logic [npss_pkg::CoordW-1:0]  q_y,
  input  logic [npss_pkg::LookW-1:0]   lookahead,
  input  logic [npss_pkg::CountW-1:0]  n_pts,
  input  npss_pkg::npss_cmd_t          cmd,
  input  logic [PtW-1:0]               seg_idx,
  output npss_pkg::npss_stat_t         stat,
  output logic [npss_pkg::IdxW-1:0]    goal,
  output logic                         found
);
  import npss_pkg::*;

  localparam int SqrtSteps = SumW / 2 + 1; // 26 result bits
  localparam int DivSteps  = RatioW + 10;  // quotient bits kept, then saturate
  localparam int NumW      = DistW + 1 + 16;
  localparam int StW       = $clog2(DivSteps + 1);

  logic [CoordW-1:0] mem_x [MaxPoints];
  logic [CoordW-1:0] mem_y [MaxPoints];
  logic [CoordW-1:0] ax_r, ay_r, bx_r, by_r, rx_r, ry_r;
  logic [PtW-1:0]    rd_a, rd_b;
  logic [PtW-1:0]    end_r;
  logic              dist_done_r, div_done_r;

  // Waypoint memory, written by loads; two reads of the segment ends
  assign rd_a = seg_idx;
  assign rd_b = seg_idx + PtW'(1);
  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_slot} < (SlotW+1)'(MaxPoints))) begin
      mem_x[PtW'(wr_slot)] <= wr_x;
      mem_y[PtW'(wr_slot)] <= wr_y;
    end
    if (cmd.load_pts) begin
      ax_r <= mem_x[rd_a];
      ay_r <= mem_y[rd_a];
      bx_r <= mem_x[rd_b];
      by_r <= mem_y[rd_b];
      end_r <= rd_b;
    end
    if (q_start) begin
      rx_r <= q_x;
      ry_r <= q_y;
    end
  end

  // Operand pick and absolute differences, combinational; squared in the sqrt block.
  logic signed [CoordW-1:0] p0x, p0y, p1x, p1y;
  logic signed [DiffW-1:0]  dx, dy;
  logic [DiffW-1:0]         ux, uy;
  always_comb begin
    p0x = ax_r; p0y = ay_r; p1x = rx_r; p1y = ry_r;
    case (cmd.dist_sel)
      SEL_DI:  begin p0x = ax_r; p0y = ay_r; end
      SEL_DJ:  begin p0x = bx_r; p0y = by_r; end
      SEL_DIJ: begin p0x = ax_r; p0y = ay_r; p1x = bx_r; p1y = by_r; end
      default: begin p0x = ax_r; p0y = ay_r; end
    endcase
    dx = DiffW'(p0x) - DiffW'(p1x);
    dy = DiffW'(p0y) - DiffW'(p1y);
    ux = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    uy = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
  end

  // Square root: two sequential squaring steps, a sum step, then one result bit a cycle
  logic [2:0]          sq_ph_r;
  logic [SqW-1:0]      sqx_r, sqy_r;
  logic [SumW+1:0]     rem_r;
  logic [DistW-1:0]    root_r;
  logic [SumW+1:0]     rad_r;
  logic [5:0]          scnt_r;
  logic                sq_busy_r;
  logic [SumW+1:0]     trial;
  logic [DistW-1:0]    di_r, dj_r, dij_r;

  assign trial = {rem_r[SumW-1:0], rad_r[SumW+1:SumW]} -
                 (SumW+2)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_ph_r <= '0;
      dist_done_r <= 1'b0;
    end else begin
      dist_done_r <= 1'b0;
      if (cmd.dist_start) begin
        sq_busy_r <= 1'b1;
        sq_ph_r <= 3'd1;
        sqx_r <= SqW'(ux) * SqW'(ux);
      end else if (sq_busy_r) begin
        if (sq_ph_r == 3'd1) begin
          sqy_r <= SqW'(uy) * SqW'(uy);
          sq_ph_r <= 3'd2;
        end else if (sq_ph_r == 3'd2) begin
          // shift by one so the bit pairs line up on even positions
          rad_r <= ((SumW+2)'(sqx_r) + (SumW+2)'(sqy_r)) << 1;
          rem_r <= '0;
          root_r <= '0;
          scnt_r <= 6'(SqrtSteps);
          sq_ph_r <= 3'd3;
        end else begin
          rad_r <= {rad_r[SumW-1:0], 2'b00};
          if (!trial[SumW+1]) begin
            rem_r <= trial;
            root_r <= {root_r[DistW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[SumW-1:0], rad_r[SumW+1:SumW]};
            root_r <= {root_r[DistW-2:0], 1'b0};
          end
          scnt_r <= scnt_r - 6'd1;
          if (scnt_r == 6'd1) begin
            sq_busy_r <= 1'b0;
            dist_done_r <= 1'b1;
          end
        end
      end
    end
  end

  logic [DistW-1:0] root_fin;
  assign root_fin = trial[SumW+1] ? {root_r[DistW-2:0], 1'b0}
                                  : {root_r[DistW-2:0], 1'b1};
  always_ff @(posedge clk) begin
    if (sq_busy_r && sq_ph_r == 3'd3 && scnt_r == 6'd1) begin
      case (cmd.dist_sel)
        SEL_DI:  di_r <= root_fin;
        SEL_DJ:  dj_r <= root_fin;
        default: dij_r <= root_fin;
      endcase
    end
  end

  // Restoring divider: numerator << 16 over dij, one quotient bit a cycle
  logic [NumW-1:0]  dnum_r;
  logic [DistW:0]   drem_r;
  logic [DivSteps-1:0] quo_r;
  logic [StW-1:0]   dcnt_r;
  logic             dv_busy_r;
  logic [DistW:0]   dsum;
  logic [DistW+1:0] dtry;
  assign dsum = (DistW+1)'(di_r) + (DistW+1)'(dj_r);
  assign dtry = {drem_r, dnum_r[NumW-1]} - (DistW+2)'(dij_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        dv_busy_r <= 1'b1;
        dnum_r <= (dsum > (DistW+1)'(dij_r)) ?
                  {dsum - (DistW+1)'(dij_r), 16'd0} : '0;
        drem_r <= '0;
        quo_r <= '0;
        dcnt_r <= StW'(NumW);
      end else if (dv_busy_r) begin
        dnum_r <= {dnum_r[NumW-2:0], 1'b0};
        if (!dtry[DistW+1]) begin
          drem_r <= dtry[DistW:0];
          quo_r <= {quo_r[DivSteps-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[DistW-1:0], dnum_r[NumW-1]};
          quo_r <= {quo_r[DivSteps-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - StW'(1);
        if (dcnt_r == StW'(1)) begin
          dv_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
  end

  // Status back to the controller
  assign stat = '{dist_done: dist_done_r, div_done: div_done_r,
                  dij_zero: (dij_r == '0)};

  // Best ratio tracking
  logic [RatioW-1:0] ratio, best_r;
  logic              have_r;
  logic [IdxW-1:0]   best_end_r;
  logic [CountW:0]   n_eff;
  assign ratio = (|quo_r[DivSteps-1:RatioW]) ? '1 : quo_r[RatioW-1:0];
  assign n_eff = ({1'b0, n_pts} > (CountW+1)'(MaxPoints)) ?
                 (CountW+1)'(MaxPoints) : {1'b0, n_pts};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (cmd.clear_best) begin
      have_r <= 1'b0;
    end else if (cmd.update && (!have_r || ratio < best_r)) begin
      have_r <= 1'b1;
      best_r <= ratio;
      if ((dj_r < DistW'(lookahead)) &&
          ((CountW+1)'(end_r) < n_eff - (CountW+1)'(1)))
        best_end_r <= IdxW'(end_r + PtW'(1));
      else
        best_end_r <= IdxW'(end_r);
    end
  end

  // A query that finishes at its start cycle sees the winner already cleared
  always_comb begin
    if (n_eff == '0) begin
      goal = '0;
      found = 1'b0;
    end else if (!have_r || cmd.clear_best) begin
      goal = IdxW'(n_eff - (CountW+1)'(1));
      found = 1'b0;
    end else begin
      goal = best_end_r;
      found = 1'b1;
    end
  end
endmodule

>>> rtl/nearest_path_segment_search.sv
// Top level of the nearest path segment search; joins controller and datapath.
// Depends on npss_pkg, npss_if, npss_ctrl, npss_dp.
//
//  channel | dir | payload
//  in_     | in  | func, slot, pos_x, pos_y
//  out_    | out | goal_index, found
//  cfg_    | in  | we, idx, data
//
// A load is written to the waypoint memory when accepted. A query holds off the
// input while it runs: per segment a read, three square roots (26 root steps each),
// a divide (43 steps) and a step; a zero-length segment skips the divide.
// With fewer than two points the result is registered at the accept edge.
// Reset is synchronous; waypoint memory is not cleared.
// A finished result waits in the output register; the next request is taken
// once the search is idle and the output register is not stalled.
module nearest_path_segment_search #(
  parameter int MaxPoints = npss_pkg::DefMaxPoints
) (
  input  logic clk,
  input  logic rst_n,
  npss_if.sink   in_ch,
  npss_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [npss_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [npss_pkg::CfgDataW-1:0] cfg_data
);
  import npss_pkg::*;
  localparam int PtW = $clog2(MaxPoints);

  logic [LookW-1:0]  look_r;
  logic [CountW-1:0] npts_r;
  npss_cmd_t  cmd;
  npss_stat_t stat;
  logic [PtW-1:0] seg_idx;
  logic busy, done, acc, q_start;
  logic [IdxW-1:0] goal;
  logic found;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r <= LookW'(256);
      npts_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOOKAHEAD: look_r <= cfg_data[LookW-1:0];
        CFG_POINTS:    npts_r <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy && !(out_ch.valid && !out_ch.ready);
  assign acc = in_ch.valid && in_ch.ready;
  assign q_start = acc && (in_ch.data.func == FUNC_QUERY);

  npss_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
    .clk, .rst_n, .start(q_start), .n_pts(npts_r), .stat, .cmd,
    .seg_idx, .busy, .done
  );

  npss_dp #(.MaxPoints(MaxPoints)) u_dp (
    .clk, .rst_n,
    .wr_en(acc && (in_ch.data.func == FUNC_LOAD)),
    .wr_slot(in_ch.data.slot), .wr_x(in_ch.data.pos_x), .wr_y(in_ch.data.pos_y),
    .q_start, .q_x(in_ch.data.pos_x), .q_y(in_ch.data.pos_y),
    .lookahead(look_r), .n_pts(npts_r), .cmd, .seg_idx, .stat,
    .goal, .found
  );

  // Output register
  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (done) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_ch.data.goal_index <= goal;
      out_ch.data.found <= found;
    end
  end
  assign out_ch.valid = ov_r;
endmodule

>>> rtl/npss_checker.sv
// Port-level checks for the segment search top level, bound to it.
// Depends on assert_macros.svh and the top level's ports.
`include "assert_macros.svh"
module npss_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found
);
  `CHK_IMPL(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `CHK_IMPL(a_stall, clk, rst_n, out_valid && !out_ready |-> !in_ready)
  `CHK_IMPL(a_found, clk, rst_n, out_valid && !out_ready |=> $stable(out_found))
  `CHK_ALWAYS(a_rst, clk, !rst_n |=> !out_valid)
endmodule

bind nearest_path_segment_search npss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_found(out_ch.data.found)
);

>>> tb/sv/nearest_path_segment_search_tb.sv
// Testbench for nearest_path_segment_search: loads waypoint tables, runs queries, checks goals.
// Depends on npss_pkg, npss_if and the RTL top level; expected goals come from a local search.
`timescale 1ns / 100ps

module nearest_path_segment_search_tb;
  import npss_pkg::*;

  localparam int TableDepth = 16;
  localparam int SettleCycles = 20;

  typedef struct packed {
    logic                     func;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
  } request_t;

  typedef struct packed {
    logic [IdxW-1:0] goal_index;
    logic            found;
  } goal_t;

  // Mirror of the search: waypoint table, registers and pending goals.
  class goal_tracker;
    logic [LookW-1:0]         lookahead;
    logic [CountW-1:0]        points;
    logic signed [CoordW-1:0] wp_x [TableDepth];
    logic signed [CoordW-1:0] wp_y [TableDepth];
    goal_t                    goals_due [$];
    int                       errors;

    function new();
      lookahead = LookW'(256);
      points = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_LOOKAHEAD) lookahead = data[LookW-1:0];
      else points = data[CountW-1:0];
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    static function longint unsigned span(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return int_sqrt(dx * dx + dy * dy);
    endfunction

    // Accepted request: a load updates the table, a query queues its goal.
    function void note_request(request_t r);
      int n, best_end;
      bit have;
      longint unsigned best, di, dj, dij, num, ratio;
      longint rx, ry;
      goal_t g;
      if (r.func == FUNC_LOAD) begin
        wp_x[r.slot] = r.pos_x;
        wp_y[r.slot] = r.pos_y;
        return;
      end
      n = (points > TableDepth) ? TableDepth : int'(points);
      g = '0;
      if (n > 0) begin
        have = 0;
        best = 0;
        best_end = 0;
        rx = longint'(r.pos_x);
        ry = longint'(r.pos_y);
        for (int i = 0; i + 1 < n; i++) begin
          di = span(wp_x[i], wp_y[i], rx, ry);
          dj = span(wp_x[i+1], wp_y[i+1], rx, ry);
          dij = span(wp_x[i], wp_y[i], wp_x[i+1], wp_y[i+1]);
          if (dij == 0) continue;
          num = (di + dj > dij) ? di + dj - dij : 0;
          ratio = (num << 16) / dij;
          if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
          if (!have || ratio < best) begin
            have = 1;
            best = ratio;
            best_end = i + 1;
            if (dj < longint'(lookahead) && best_end < n - 1) best_end++;
          end
        end
        g.found = have;
        g.goal_index = have ? IdxW'(best_end) : IdxW'(n - 1);
      end
      goals_due = {goals_due, g};
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $realtime, msg);
    endtask

    task check_goal(goal_t got);
      goal_t want;
      if (goals_due.size() == 0) begin
        report($sformatf("unexpected goal %0d found %0d", got.goal_index, got.found));
        return;
      end
      want = goals_due.pop_front();
      if (got.goal_index !== want.goal_index)
        report($sformatf("goal_index %0d, expected %0d", got.goal_index, want.goal_index));
      if (got.found !== want.found)
        report($sformatf("found %0d, expected %0d", got.found, want.found));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  bit   no_idle;
  bit   held_off;
  int   goals_seen;

  npss_if #(.payload_t(request_t)) req_ch (clk);
  npss_if #(.payload_t(goal_t))    goal_ch (clk);

  goal_tracker tracker;

  nearest_path_segment_search DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_ch.sink),
    .out_ch  (goal_ch.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("nearest_path_segment_search regression: fail");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(14, 0);
  endfunction

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    int gap;
    gap = 0;
    goals_seen = 0;
    held_off = 0;
    goal_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (goal_ch.valid && goal_ch.ready) begin
        tracker.check_goal(goal_ch.data);
        goals_seen++;
        gap = draw_gap();
        if (goals_seen == 40 && !held_off) begin
          held_off = 1;
          gap = 4000;
        end
      end
      if (gap > 0) begin
        goal_ch.ready <= 1'b0;
        gap--;
      end else begin
        goal_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request after a random gap; called and returns at a clock edge.
  task automatic send_request(logic func, logic [SlotW-1:0] slot,
                              logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    request_t r;
    int gap;
    r.func = func;
    r.slot = slot;
    r.pos_x = x;
    r.pos_y = y;
    gap = draw_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(r);
  endtask

  // Drain all pending goals, then let a trailing load settle.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.goals_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    int unsigned mode;
    mode = $urandom_range(9, 0);
    if (mode < 7) return CoordW'($signed($urandom_range(8191, 0)) - 4096);
    if (mode == 7) return $urandom_range(1, 0) ? 24'h7FFFFF : 24'h800000;
    return CoordW'($urandom);
  endfunction

  function automatic logic [CfgDataW-1:0] rand_lookahead();
    int unsigned mode;
    mode = $urandom_range(7, 0);
    if (mode == 0) return '0;
    if (mode == 1) return 23'h7FFFFF;
    if (mode == 2) return CfgDataW'($urandom);
    return CfgDataW'($urandom_range(2048, 0));
  endfunction

  initial begin
    int sent, phase_len;
    int unsigned pick;
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table straight after reset.
    send_request(FUNC_QUERY, 4'd9, 24'h000100, 24'hFFFF00);
    // Fill every slot: a zero-length segment at 2-3, coordinate extremes at the end.
    for (int s = 0; s < TableDepth; s++) begin
      if (s == 3)
        send_request(FUNC_LOAD, SlotW'(s), 24'h000200, 24'h000000);
      else if (s == 14)
        send_request(FUNC_LOAD, SlotW'(s), 24'h800000, 24'h7FFFFF);
      else if (s == 15)
        send_request(FUNC_LOAD, SlotW'(s), 24'h7FFFFF, 24'h800000);
      else
        send_request(FUNC_LOAD, SlotW'(s), CoordW'(s * 256), 24'h000000);
    end
    drain();
    // One point: no segment to search.
    write_reg(CFG_POINTS, CfgDataW'(1));
    send_request(FUNC_QUERY, 4'd0, 24'h000080, 24'h000080);
    drain();
    // Four points, with the zero-length segment last.
    write_reg(CFG_POINTS, CfgDataW'(4));
    send_request(FUNC_LOAD, 4'd2, 24'h000200, 24'h000000);
    send_request(FUNC_QUERY, 4'd0, 24'h000180, 24'h000040);
    drain();
    // Full table, count beyond the table, lookahead extremes.
    write_reg(CFG_POINTS, CfgDataW'(16));
    write_reg(CFG_LOOKAHEAD, '0);
    send_request(FUNC_QUERY, 4'd0, 24'h000300, 24'h000010);
    send_request(FUNC_QUERY, 4'd0, 24'h800000, 24'h800000);
    drain();
    write_reg(CFG_POINTS, CfgDataW'(31));
    write_reg(CFG_LOOKAHEAD, 23'h7FFFFF);
    send_request(FUNC_QUERY, 4'd0, 24'h7FFFFF, 24'h7FFFFF);
    send_request(FUNC_QUERY, 4'd0, 24'h000500, 24'hFFFFF0);
    drain();

    // Random phases: new registers, then loads and queries on a random point count.
    sent = 24;
    while (sent < 580) begin
      drain();
      no_idle = ($urandom_range(3, 0) == 0);
      write_reg(CFG_LOOKAHEAD, rand_lookahead());
      pick = $urandom_range(9, 0);
      if (pick == 0) write_reg(CFG_POINTS, CfgDataW'($urandom_range(31, 17)));
      else if (pick < 3) write_reg(CFG_POINTS, CfgDataW'($urandom_range(16, 0)));
      else write_reg(CFG_POINTS, CfgDataW'($urandom_range(6, 0)));
      phase_len = $urandom_range(40, 15);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(9, 0) < 3)
          send_request(FUNC_LOAD, SlotW'($urandom), rand_coord(), rand_coord());
        else
          send_request(FUNC_QUERY, SlotW'($urandom), rand_coord(), rand_coord());
        sent++;
      end
    end
    drain();

    if (tracker.errors == 0) begin
      $display("nearest_path_segment_search regression: pass");
    end else begin
      $display("nearest_path_segment_search regression: fail");
    end
    $finish;
  end
endmodule
